// ----- hw/rtl/atrtd_pkg.sv -----
// Shared types and constants for the AT response terminator detector.
// No dependencies; every other file in hw/rtl refers to this package.
`default_nettype none

package atrtd_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int BANK_ADDR_W  = $clog2(BUFFER_BYTES);
    localparam int RAM_ADDR_W   = BANK_ADDR_W + 1;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
    localparam int BYTE_W       = 8;
    localparam int LENGTH_W     = 9;
    localparam int STATUS_W     = 3;
    localparam int FUNC_W       = 2;
    localparam int IDX_EXT_W    = ((COUNT_W > BYTE_W) ? COUNT_W : BYTE_W) + 1;

    // Configuration port
    localparam int REG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [REG_INDEX_W-1:0] REG_MODEM_MODE   = 1'd0;
    localparam logic [REG_INDEX_W-1:0] REG_NEWLINE_CHAR = 1'd1;
    localparam logic                   MODEM_MODE_RESET   = 1'b1;
    localparam logic [BYTE_W-1:0]      NEWLINE_CHAR_RESET = 8'd10;

    // Terminator patterns, newest byte lowest
    localparam logic [31:0] PAT_OK    = 32'h4F4B_0D0A;
    localparam logic [55:0] PAT_ERROR = 56'h45_5252_4F52_0D0A;
    localparam logic [63:0] PAT_DST   = 64'h4453_543A_2030_0D0A;
    localparam int OK_MIN_LEN    = 4;
    localparam int ERROR_MIN_LEN = 7;
    localparam int DST_MIN_LEN   = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_ONGOING = 3'd0,
        ST_NEWLINE = 3'd1,
        ST_OK      = 3'd2,
        ST_ERROR   = 3'd3,
        ST_DST     = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BYTE    = 2'd0,
        FUNC_COLLECT = 2'd1,
        FUNC_READ    = 2'd2,
        FUNC_RESTART = 2'd3
    } func_t;

    typedef struct packed {
        status_t             status;
        logic [LENGTH_W-1:0] length;
        logic [BYTE_W-1:0]   read_data;
    } out_word_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [RAM_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]     wdata;
    } ram_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/atrtd_ifs.sv -----
// Valid/ready channel interfaces for command words and response words.
// Depends on atrtd_pkg.
`default_nettype none

interface atrtd_in_if;
    logic                                valid;
    logic                                ready;
    logic [atrtd_pkg::FUNC_W-1:0]        func;
    logic [atrtd_pkg::BYTE_W-1:0]        rx_byte;
    logic [atrtd_pkg::BYTE_W-1:0]        read_index;

    modport source (output valid, output func, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input func, input rx_byte, input read_index,
                    output ready);
endinterface

interface atrtd_out_if;
    logic                                valid;
    logic                                ready;
    atrtd_pkg::status_t                  status;
    logic [atrtd_pkg::LENGTH_W-1:0]      length;
    logic [atrtd_pkg::BYTE_W-1:0]        read_data;

    modport source (output valid, output status, output length, output read_data,
                    input ready);
    modport sink   (input valid, input status, input length, input read_data,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/atrtd_msg_ram.sv -----
// Two-bank message store: one port, synchronous write, registered read.
// Depends on atrtd_pkg.
`default_nettype none

module atrtd_msg_ram (
    input  wire logic                            clk,
    input  wire atrtd_pkg::ram_req_t             req,
    output logic [atrtd_pkg::BYTE_W-1:0]         rdata
);

    localparam int RAM_DEPTH = 2 ** atrtd_pkg::RAM_ADDR_W;

    logic [atrtd_pkg::BYTE_W-1:0] mem [RAM_DEPTH];
    logic [atrtd_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/atrtd_out_queue.sv -----
// Three-word response queue; decouples the input ready from the output ready.
// Depends on atrtd_pkg and atrtd_ifs.
`default_nettype none

module atrtd_out_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire atrtd_pkg::out_word_t  push_word,
    input  wire logic                  inflight,
    output logic                       room,
    atrtd_out_if.source                rsp
);

    localparam int DEPTH = 3;
    localparam int PTR_W = 2;
    localparam int LVL_W = PTR_W + 1;

    atrtd_pkg::out_word_t entries [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] count_reg, count_next;
    logic             pop;

    assign pop = rsp.valid && rsp.ready;

    always_comb
    begin
        count_next = count_reg + PTR_W'(push) - PTR_W'(pop);
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
    end

    // a word in the memory read stage always lands here next cycle
    assign room = (LVL_W'(count_reg) + LVL_W'(inflight)) < LVL_W'(DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[tail_reg] <= push_word;
        end
    end

    assign rsp.valid     = (count_reg != '0);
    assign rsp.status    = entries[head_reg].status;
    assign rsp.length    = entries[head_reg].length;
    assign rsp.read_data = entries[head_reg].read_data;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != PTR_W'(DEPTH))
        else $error("response queue overflow");

endmodule

`default_nettype wire

// ----- hw/rtl/at_response_terminator_detector_top.sv -----
// AT response terminator detector, top level.
// Depends on atrtd_pkg, atrtd_ifs, atrtd_msg_ram and atrtd_out_queue.
//
// Usage:
//   cmd  (valid/ready sink): func, rx_byte, read_index. func selects a received
//        byte, collect message, read collected byte, or restart reception.
//   rsp  (valid/ready source): status, length, read_data; one word per cmd word,
//        in order.
//   cfg_we/cfg_index/cfg_data: register writes (modem_mode, newline_char);
//        write only while no command is in flight.
// Bytes go into the active bank of a two-bank message store; a collect swaps
// banks so reads see the finished message while the next one arrives.
// Path: a response is registered in the message store read stage, then enters
// the response queue, from which rsp presents it.
// Throughput: one command per cycle when not stalled, set by the single port.
// Reset: control state cleared, modem_mode = 1, newline_char = 10; the store
// is not cleared, and a command is accepted right after reset.
// Stall: cmd.ready drops once the three-word response queue and the read stage
// together hold three words, and rises again as rsp words are taken.
`default_nettype none

module at_response_terminator_detector_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    atrtd_in_if.sink                                  cmd,
    atrtd_out_if.source                               rsp,
    input  wire logic                                 cfg_we,
    input  wire logic [atrtd_pkg::REG_INDEX_W-1:0]    cfg_index,
    input  wire logic [atrtd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = atrtd_pkg::COUNT_W;
    localparam int LW = atrtd_pkg::LENGTH_W;
    localparam int XW = atrtd_pkg::IDX_EXT_W;
    localparam int AW = atrtd_pkg::BANK_ADDR_W;

    // configuration
    logic                          modem_mode_reg;
    logic [atrtd_pkg::BYTE_W-1:0]  newline_char_reg;

    // reception state
    logic [CW-1:0]      write_count_reg, write_count_next;
    atrtd_pkg::status_t msg_status_reg, msg_status_next;
    logic               bank_reg, bank_next;
    logic [CW-1:0]      collected_reg, collected_next;
    logic [63:0]        recent_reg, recent_next;

    // memory read stage
    logic               s1_valid_reg;
    atrtd_pkg::status_t s1_status_reg;
    logic [LW-1:0]      s1_length_reg;
    logic               s1_use_data_reg;

    atrtd_pkg::status_t word_status;
    logic [LW-1:0]      word_length;
    logic               word_use_data;

    atrtd_pkg::ram_req_t  ram_req;
    logic [atrtd_pkg::BYTE_W-1:0] ram_rdata;
    atrtd_pkg::out_word_t push_word;
    logic                 room;
    logic                 cmd_fire;

    logic [CW-1:0]      count_inc;
    logic [63:0]        recent_shift;
    atrtd_pkg::status_t term_status;
    logic [XW-1:0]      idx_ext;
    logic               idx_in_range;

    assign cmd.ready = room;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign count_inc    = write_count_reg + 1'b1;
    assign recent_shift = {recent_reg[55:0], cmd.rx_byte};
    assign idx_ext      = XW'(cmd.read_index);
    assign idx_in_range = (idx_ext < XW'(collected_reg))
                       && (idx_ext < XW'(atrtd_pkg::BUFFER_BYTES));

    // end-of-message check for a byte taken in the ongoing state
    always_comb
    begin
        term_status = atrtd_pkg::ST_ONGOING;
        if (cmd.rx_byte == newline_char_reg)
        begin
            if (modem_mode_reg)
            begin
                // later checks win: OK over ERROR over DST
                if (count_inc >= CW'(atrtd_pkg::DST_MIN_LEN)
                    && recent_shift == atrtd_pkg::PAT_DST)
                begin
                    term_status = atrtd_pkg::ST_DST;
                end
                if (count_inc >= CW'(atrtd_pkg::ERROR_MIN_LEN)
                    && recent_shift[55:0] == atrtd_pkg::PAT_ERROR)
                begin
                    term_status = atrtd_pkg::ST_ERROR;
                end
                if (count_inc >= CW'(atrtd_pkg::OK_MIN_LEN)
                    && recent_shift[31:0] == atrtd_pkg::PAT_OK)
                begin
                    term_status = atrtd_pkg::ST_OK;
                end
            end
            else
            begin
                term_status = atrtd_pkg::ST_NEWLINE;
            end
        end
        if (count_inc >= CW'(atrtd_pkg::BUFFER_BYTES))
        begin
            term_status = atrtd_pkg::ST_FULL;
        end
    end

    always_comb
    begin
        write_count_next = write_count_reg;
        msg_status_next  = msg_status_reg;
        bank_next        = bank_reg;
        collected_next   = collected_reg;
        recent_next      = recent_reg;
        word_status      = atrtd_pkg::ST_ONGOING;
        word_length      = '0;
        word_use_data    = 1'b0;
        ram_req.we       = 1'b0;
        ram_req.re       = 1'b0;
        ram_req.addr     = {bank_reg, write_count_reg[AW-1:0]};
        ram_req.wdata    = cmd.rx_byte;
        if (cmd_fire)
        begin
            case (cmd.func)
                atrtd_pkg::FUNC_BYTE:
                begin
                    word_status = msg_status_reg;
                    word_length = LW'(write_count_reg);
                    if (msg_status_reg == atrtd_pkg::ST_ONGOING)
                    begin
                        write_count_next = count_inc;
                        recent_next      = recent_shift;
                        msg_status_next  = term_status;
                        ram_req.we       = 1'b1;
                        word_status      = term_status;
                        word_length      = LW'(count_inc);
                    end
                end
                atrtd_pkg::FUNC_COLLECT:
                begin
                    word_length = LW'(collected_reg);
                    if (msg_status_reg != atrtd_pkg::ST_ONGOING)
                    begin
                        word_status      = msg_status_reg;
                        word_length      = LW'(write_count_reg);
                        collected_next   = write_count_reg;
                        bank_next        = !bank_reg;
                        write_count_next = '0;
                        msg_status_next  = atrtd_pkg::ST_ONGOING;
                        recent_next      = '0;
                    end
                end
                atrtd_pkg::FUNC_READ:
                begin
                    word_status   = msg_status_reg;
                    word_length   = LW'(collected_reg);
                    word_use_data = idx_in_range;
                    ram_req.re    = idx_in_range;
                    ram_req.addr  = {!bank_reg, idx_ext[AW-1:0]};
                end
                default:
                begin
                    write_count_next = '0;
                    msg_status_next  = atrtd_pkg::ST_ONGOING;
                    recent_next      = '0;
                    collected_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modem_mode_reg   <= atrtd_pkg::MODEM_MODE_RESET;
            newline_char_reg <= atrtd_pkg::NEWLINE_CHAR_RESET;
            write_count_reg  <= '0;
            msg_status_reg   <= atrtd_pkg::ST_ONGOING;
            bank_reg         <= 1'b0;
            collected_reg    <= '0;
            recent_reg       <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == atrtd_pkg::REG_MODEM_MODE)
            begin
                modem_mode_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == atrtd_pkg::REG_NEWLINE_CHAR)
            begin
                newline_char_reg <= cfg_data[atrtd_pkg::BYTE_W-1:0];
            end
            write_count_reg <= write_count_next;
            msg_status_reg  <= msg_status_next;
            bank_reg        <= bank_next;
            collected_reg   <= collected_next;
            recent_reg      <= recent_next;
            s1_valid_reg    <= cmd_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_status_reg   <= word_status;
            s1_length_reg   <= word_length;
            s1_use_data_reg <= word_use_data;
        end
    end

    atrtd_msg_ram u_msg_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign push_word.status    = s1_status_reg;
    assign push_word.length    = s1_length_reg;
    assign push_word.read_data = s1_use_data_reg ? ram_rdata : '0;

    atrtd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_word (push_word),
        .inflight  (s1_valid_reg),
        .room      (room),
        .rsp       (rsp)
    );

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        msg_status_reg == atrtd_pkg::ST_FULL
            |-> write_count_reg == CW'(atrtd_pkg::BUFFER_BYTES))
        else $error("full status without a full bank");

    a_ongoing_room: assert property (@(posedge clk) disable iff (!rst_n)
        msg_status_reg == atrtd_pkg::ST_ONGOING
            |-> write_count_reg < CW'(atrtd_pkg::BUFFER_BYTES))
        else $error("ongoing message with no room left in bank");

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("message store write and read in one cycle");

endmodule

`default_nettype wire
